FILE: rtl/scmc_pkg.sv
package scmc_pkg;

  // Character codes used by the line parser
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Command values
  localparam logic [7:0]  SPEED_DEFAULT = 8'd255;
  localparam logic [8:0]  SPEED_MAX     = 9'd255;
  localparam logic [8:0]  SPEED_SAT     = 9'd256;
  localparam logic [30:0] TICKS_SAT     = 31'h7FFF_FFFF;

  // Bridge pin codes, bit 0 drives A, bit 1 drives B
  localparam logic [1:0] PINS_OFF  = 2'b00;
  localparam logic [1:0] PINS_FWD  = 2'b01;
  localparam logic [1:0] PINS_BACK = 2'b10;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_DOWN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_WIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_WIN   = 2'd2;
  localparam logic [15:0] NEAR_WIN_RST = 16'd50;
  localparam logic [15:0] FAR_WIN_RST  = 16'd100;

  // Four fifths by reciprocal: (p * 4 * 205) >> 10, exact for p below 256
  localparam logic [17:0] FOUR_FIFTHS_MUL = 18'd820;

  // Event queue between parser and motor
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_TICK,
    EV_GO,
    EV_STOP,
    EV_UNKNOWN
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [1:0]  pins;
    logic [7:0]  speed;
    logic [30:0] ticks;
  } ev_t;

endpackage

FILE: rtl/serial_command_motor_controller.sv
// Serial command motor controller.
// Input channel (in_valid/in_ready): one beat per received serial byte
// (in_mode = 0, in_rx_byte) or per encoder tick (in_mode = 1). Bytes form
// lines ended by CR: a direction letter f, b or s, an optional decimal speed
// and an optional comma with a tick count.
// Result channel (out_valid/out_ready): exactly one beat per input beat, in
// order, carrying the bridge pins, PWM duty, moving flag and the per-beat
// flags target_reached, command_done and command_unknown.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 slowdown
// enable, 1 near window, 2 far window; write only while the block is idle.
// Each accepted beat passes through the event queue into the result register.
// Throughput: one beat per cycle unless stalled; the parser classifies each
// byte combinationally and the motor unit applies one queued event per cycle.
// Stall: the result register holds while out_ready is low; the four-entry
// event queue then fills and in_ready drops once it is full.
// Reset: synchronous active low; motor stopped, duty and counters zero,
// windows 50 and 100, slowdown off, queue and result register empty.
module serial_command_motor_controller
  import scmc_pkg::*;
#(
  parameter int unsigned LINE_LIMIT = 201,
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_drive_a,
  output logic                 out_drive_b,
  output logic [7:0]           out_duty,
  output logic                 out_moving,
  output logic                 out_target_reached,
  output logic                 out_command_done,
  output logic                 out_command_unknown,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic accept;
  logic q_full, q_empty, q_pop;
  ev_t  push_ev, head_ev;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  scmc_parser #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .mode    (in_mode),
    .rx_byte (in_rx_byte),
    .ev      (push_ev)
  );

  scmc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept),
    .push_ev (push_ev),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head_ev (head_ev)
  );

  scmc_motor #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_motor (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .ev_avail            (!q_empty),
    .ev                  (head_ev),
    .ev_pop              (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_drive_a         (out_drive_a),
    .out_drive_b         (out_drive_b),
    .out_duty            (out_duty),
    .out_moving          (out_moving),
    .out_target_reached  (out_target_reached),
    .out_command_done    (out_command_done),
    .out_command_unknown (out_command_unknown)
  );

endmodule

FILE: rtl/scmc_parser.sv
module scmc_parser
  import scmc_pkg::*;
#(
  parameter int unsigned LINE_LIMIT = 201
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       mode,
  input  logic [7:0] rx_byte,
  output ev_t        ev
);

  localparam int unsigned LEN_W = $clog2(LINE_LIMIT + 1);

  typedef enum logic [6:0] {
    PH_DIR       = 7'b0000001,
    PH_AFTER_DIR = 7'b0000010,
    PH_SPEED     = 7'b0000100,
    PH_TICKS     = 7'b0001000,
    PH_END_SPEED = 7'b0010000,
    PH_END_DIR   = 7'b0100000,
    PH_END_EMPTY = 7'b1000000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [7:0]        letter_r, letter_nxt;
  logic [8:0]        speed_r, speed_nxt;
  logic [30:0]       ticks_r, ticks_nxt;
  logic              bad_r, bad_nxt;

  logic              is_digit;
  logic [3:0]        digit;
  logic [11:0]       speed_mac;
  logic [34:0]       ticks_mac;
  logic [7:0]        dir;
  logic [8:0]        spd;
  logic [30:0]       tks;

  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit     = rx_byte[3:0];
  assign speed_mac = (12'(speed_r) << 3) + (12'(speed_r) << 1) + 12'(digit);
  assign ticks_mac = (35'(ticks_r) << 3) + (35'(ticks_r) << 1) + 35'(digit);

  // Resolve the finished line into a command
  always_comb begin
    dir = letter_r;
    spd = 9'(SPEED_DEFAULT);
    tks = '0;
    case (phase_r)
      PH_DIR, PH_END_EMPTY: dir = CH_NUL;
      PH_SPEED, PH_TICKS, PH_END_SPEED: begin
        spd = speed_r;
        tks = ticks_r;
        if (bad_r || (speed_r == 9'd0) || (speed_r > SPEED_MAX)) begin
          dir = CH_S;
        end
      end
      default: ;
    endcase
  end

  // Classify the beat and advance the line state
  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    letter_nxt = letter_r;
    speed_nxt  = speed_r;
    ticks_nxt  = ticks_r;
    bad_nxt    = bad_r;
    ev.kind    = EV_NONE;
    ev.pins    = PINS_OFF;
    ev.speed   = spd[7:0];
    ev.ticks   = tks;
    if (mode) begin
      ev.kind = EV_TICK;
    end else if (rx_byte == CH_CR) begin
      case (dir)
        CH_F: begin
          ev.kind = EV_GO;
          ev.pins = PINS_FWD;
        end
        CH_B: begin
          ev.kind = EV_GO;
          ev.pins = PINS_BACK;
        end
        CH_S:    ev.kind = EV_STOP;
        default: ev.kind = EV_UNKNOWN;
      endcase
      phase_nxt  = PH_DIR;
      len_nxt    = '0;
      letter_nxt = CH_NUL;
      speed_nxt  = '0;
      ticks_nxt  = '0;
      bad_nxt    = 1'b0;
    end else if ((rx_byte != CH_LF) && (len_r < LEN_W'(LINE_LIMIT))) begin
      len_nxt = len_r + 1'b1;
      case (phase_r)
        PH_DIR: begin
          if (rx_byte == CH_NUL) begin
            phase_nxt = PH_END_EMPTY;
          end else begin
            letter_nxt = rx_byte;
            phase_nxt  = PH_AFTER_DIR;
          end
        end
        PH_AFTER_DIR, PH_SPEED: begin
          if ((rx_byte == CH_NUL) && (phase_r == PH_AFTER_DIR)) begin
            phase_nxt = PH_END_DIR;
          end else if (is_digit) begin
            if (!bad_r) begin
              if (speed_mac > 12'(SPEED_MAX)) begin
                bad_nxt   = 1'b1;
                speed_nxt = SPEED_SAT;
              end else begin
                speed_nxt = speed_mac[8:0];
              end
            end
            phase_nxt = PH_SPEED;
          end else if ((rx_byte == CH_COMMA) && (phase_r == PH_SPEED)) begin
            phase_nxt = PH_TICKS;
          end else begin
            phase_nxt = PH_END_SPEED;
          end
        end
        PH_TICKS: begin
          if (is_digit) begin
            ticks_nxt = (ticks_mac > 35'(TICKS_SAT)) ? TICKS_SAT : ticks_mac[30:0];
          end else begin
            phase_nxt = PH_END_SPEED;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold line state between beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_DIR;
      len_r    <= '0;
      letter_r <= CH_NUL;
      speed_r  <= '0;
      ticks_r  <= '0;
      bad_r    <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      letter_r <= letter_nxt;
      speed_r  <= speed_nxt;
      ticks_r  <= ticks_nxt;
      bad_r    <= bad_nxt;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(LINE_LIMIT))
    else $error("line length beyond limit");

  a_cr_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !mode && (rx_byte == CH_CR)) |=> (phase_r == PH_DIR) && (len_r == '0))
    else $error("line state not cleared after CR");

  a_bad_sat: assert property (@(posedge clk) disable iff (!rst_n)
    bad_r |-> (speed_r == SPEED_SAT))
    else $error("bad speed not saturated");

endmodule

FILE: rtl/scmc_queue.sv
module scmc_queue
  import scmc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ev_t  push_ev,
  output logic full,
  input  logic pop,
  output logic empty,
  output ev_t  head_ev
);

  ev_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head_ev = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: ;
    endcase
  end

  // Store the event beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_ev;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (QPTR_W)'(wr_r - rd_r) == cnt_r[QPTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

FILE: rtl/scmc_motor.sv
module scmc_motor
  import scmc_pkg::*;
#(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 ev_avail,
  input  ev_t                  ev,
  output logic                 ev_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_drive_a,
  output logic                 out_drive_b,
  output logic [7:0]           out_duty,
  output logic                 out_moving,
  output logic                 out_target_reached,
  output logic                 out_command_done,
  output logic                 out_command_unknown
);

  localparam int unsigned SUMW = ((TICK_WIDTH > 31) ? TICK_WIDTH : 31) + 1;
  localparam int unsigned WINW = TICK_WIDTH + 1;
  localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

  logic                  slow_r;
  logic [15:0]           near_r, far_r;
  logic [TICK_WIDTH-1:0] count_r, count_nxt;
  logic [TICK_WIDTH-1:0] target_r, target_nxt;
  logic [7:0]            power_r, power_nxt;
  logic [7:0]            duty_r, duty_nxt;
  logic [1:0]            pins_r, pins_nxt;
  logic                  moving_r, moving_nxt;
  logic                  reached, done, unknown;

  logic                  out_valid_r;
  logic [1:0]            out_pins_r;
  logic [7:0]            out_duty_r;
  logic                  out_moving_r, out_reached_r, out_done_r, out_unknown_r;

  logic [TICK_WIDTH-1:0] cnt_inc;
  logic [SUMW-1:0]       go_sum;
  logic [WINW-1:0]       near_sum, far_sum;
  logic [17:0]           p45_full;
  logic [7:0]            slow_val;

  assign ev_pop   = ev_avail && (!out_valid_r || out_ready);
  assign cnt_inc  = (count_r == TICK_MAX) ? count_r : count_r + 1'b1;
  assign go_sum   = SUMW'(count_r) + SUMW'(ev.ticks);
  assign near_sum = WINW'(cnt_inc) + WINW'(near_r);
  assign far_sum  = WINW'(cnt_inc) + WINW'(far_r);
  assign p45_full = 18'(power_r) * FOUR_FIFTHS_MUL;

  // Pick the reduced duty for the window the count sits in
  always_comb begin
    slow_val = '0;
    if (near_sum > WINW'(target_r)) begin
      slow_val = power_r >> 1;
    end else if (far_sum > WINW'(target_r)) begin
      slow_val = p45_full[17:10];
    end
  end

  // Carry out the event at the head of the queue
  always_comb begin
    count_nxt  = count_r;
    target_nxt = target_r;
    power_nxt  = power_r;
    duty_nxt   = duty_r;
    pins_nxt   = pins_r;
    moving_nxt = moving_r;
    reached    = 1'b0;
    done       = 1'b0;
    unknown    = 1'b0;
    case (ev.kind)
      EV_TICK: begin
        count_nxt = cnt_inc;
        if (target_r != '0) begin
          if (cnt_inc > target_r) begin
            moving_nxt = 1'b0;
            target_nxt = '0;
            pins_nxt   = PINS_OFF;
            reached    = 1'b1;
          end else if (slow_r && (slow_val != '0)) begin
            duty_nxt = slow_val;
          end
        end
      end
      EV_GO: begin
        power_nxt  = ev.speed;
        duty_nxt   = ev.speed;
        moving_nxt = 1'b1;
        pins_nxt   = ev.pins;
        done       = 1'b1;
        if (ev.ticks == '0) begin
          target_nxt = '0;
        end else if (go_sum > SUMW'(TICK_MAX)) begin
          target_nxt = TICK_MAX;
        end else begin
          target_nxt = go_sum[TICK_WIDTH-1:0];
        end
      end
      EV_STOP: begin
        moving_nxt = 1'b0;
        target_nxt = '0;
        pins_nxt   = PINS_OFF;
        done       = 1'b1;
      end
      EV_UNKNOWN: unknown = 1'b1;
      default: ;
    endcase
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_r <= 1'b0;
      near_r <= NEAR_WIN_RST;
      far_r  <= FAR_WIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLOW_DOWN: slow_r <= cfg_data[0];
        REG_NEAR_WIN:  near_r <= cfg_data;
        REG_FAR_WIN:   far_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Update motor state on each popped beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      target_r <= '0;
      power_r  <= '0;
      duty_r   <= '0;
      pins_r   <= PINS_OFF;
      moving_r <= 1'b0;
    end else if (ev_pop) begin
      count_r  <= count_nxt;
      target_r <= target_nxt;
      power_r  <= power_nxt;
      duty_r   <= duty_nxt;
      pins_r   <= pins_nxt;
      moving_r <= moving_nxt;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ev_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_pop) begin
      out_pins_r    <= pins_nxt;
      out_duty_r    <= duty_nxt;
      out_moving_r  <= moving_nxt;
      out_reached_r <= reached;
      out_done_r    <= done;
      out_unknown_r <= unknown;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_drive_a         = out_pins_r[0];
  assign out_drive_b         = out_pins_r[1];
  assign out_duty            = out_duty_r;
  assign out_moving          = out_moving_r;
  assign out_target_reached  = out_reached_r;
  assign out_command_done    = out_done_r;
  assign out_command_unknown = out_unknown_r;

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_reached_r, out_done_r, out_unknown_r}))
    else $error("more than one result flag set");

  a_pins_moving: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r ? $onehot(pins_r) : (pins_r == PINS_OFF))
    else $error("bridge pins disagree with moving flag");

  a_target_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (target_r != '0) |-> moving_r)
    else $error("target held while stopped");

  a_reached_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_reached_r) |-> (!out_moving_r && (out_pins_r == PINS_OFF)))
    else $error("target reached but motor still driven");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import scmc_pkg::*;

  localparam int unsigned LINE_LIMIT   = 201;
  localparam logic [31:0] TICK_MAX     = 32'hFFFF_FFFF;
  localparam int unsigned N_DIRECTED   = 25;
  localparam int unsigned N_PHASES     = 6;
  localparam int unsigned PHASE_ITEMS  = 340;
  localparam int unsigned STALL_LIMIT  = 500;
  localparam int unsigned MAX_LONG     = 3;
  localparam logic [7:0]  CH_JUNK      = "x";

  typedef enum logic [2:0] {
    LN_DIR,
    LN_AFTER_DIR,
    LN_SPEED,
    LN_TICKS,
    LN_END_SPEED,
    LN_END_DIR,
    LN_END_EMPTY
  } line_phase_t;

  typedef enum logic [1:0] {
    LINE_DONE,
    LINE_UNKNOWN
  } line_result_t;

  typedef struct packed {
    logic       drive_a;
    logic       drive_b;
    logic [7:0] duty;
    logic       moving;
    logic       target_reached;
    logic       command_done;
    logic       command_unknown;
  } motor_status_t;

  typedef struct packed {
    logic          mode;
    logic [7:0]    ch;
    logic          typed;
    motor_status_t status;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_mode;
  logic [7:0]           in_rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_drive_a;
  logic                 out_drive_b;
  logic [7:0]           out_duty;
  logic                 out_moving;
  logic                 out_target_reached;
  logic                 out_command_done;
  logic                 out_command_unknown;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  serial_command_motor_controller dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_drive_a         (out_drive_a),
    .out_drive_b         (out_drive_b),
    .out_duty            (out_duty),
    .out_moving          (out_moving),
    .out_target_reached  (out_target_reached),
    .out_command_done    (out_command_done),
    .out_command_unknown (out_command_unknown),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predictor state: motor, line parser and registers
  logic [31:0]  m_ticks;
  logic [31:0]  m_target;
  logic [7:0]   m_power;
  logic [7:0]   m_duty;
  logic [1:0]   m_pins;
  logic         m_moving;
  logic [7:0]   ln_len;
  line_phase_t  ln_phase;
  logic [7:0]   ln_dir;
  logic [8:0]   ln_speed;
  logic [30:0]  ln_ticks;
  logic         ln_speed_bad;
  logic         cf_slow;
  logic [15:0]  cf_near;
  logic [15:0]  cf_far;

  motor_status_t status_q[$];
  logic [8:0]    line_buf[$];
  stim_row_t     directed_rows[N_DIRECTED];

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned idle_cycles;
  int unsigned long_lines;
  int unsigned sender_idle_pct;
  int unsigned sink_idle_pct;

  function automatic void clear_line();
    ln_len       = '0;
    ln_phase     = LN_DIR;
    ln_dir       = '0;
    ln_speed     = '0;
    ln_ticks     = '0;
    ln_speed_bad = 1'b0;
  endfunction

  function automatic void model_reset();
    m_ticks  = '0;
    m_target = '0;
    m_power  = '0;
    m_duty   = '0;
    m_pins   = PINS_OFF;
    m_moving = 1'b0;
    cf_slow  = 1'b0;
    cf_near  = NEAR_WIN_RST;
    cf_far   = FAR_WIN_RST;
    clear_line();
  endfunction

  function automatic void motor_halt();
    m_moving = 1'b0;
    m_target = '0;
    m_pins   = PINS_OFF;
  endfunction

  function automatic void motor_run(logic [1:0] pins, logic [7:0] speed, logic [30:0] ticks);
    logic [32:0] sum;
    m_power = speed;
    m_duty  = speed;
    if (ticks == '0) begin
      m_target = '0;
    end else begin
      sum = {1'b0, m_ticks} + {2'b0, ticks};
      m_target = (sum > {1'b0, TICK_MAX}) ? TICK_MAX : sum[31:0];
    end
    m_moving = 1'b1;
    m_pins   = pins;
  endfunction

  // Apply the finished line as a motor command
  function automatic line_result_t model_end_line();
    logic [7:0]   dir;
    logic [8:0]   speed;
    logic [30:0]  ticks;
    line_result_t res;
    dir   = ln_dir;
    speed = 9'd255;
    ticks = '0;
    if (ln_phase == LN_DIR || ln_phase == LN_END_EMPTY) begin
      dir = CH_NUL;
    end else if (ln_phase == LN_SPEED || ln_phase == LN_TICKS || ln_phase == LN_END_SPEED) begin
      speed = ln_speed;
      ticks = ln_ticks;
      if (ln_speed_bad || speed == '0 || speed > SPEED_MAX) begin
        dir = CH_S;
      end
    end
    res = LINE_DONE;
    if (dir == CH_F) begin
      motor_run(PINS_FWD, speed[7:0], ticks);
    end else if (dir == CH_B) begin
      motor_run(PINS_BACK, speed[7:0], ticks);
    end else if (dir == CH_S) begin
      motor_halt();
    end else begin
      res = LINE_UNKNOWN;
    end
    clear_line();
    return res;
  endfunction

  // Advance the parser by one character of the line
  function automatic void model_char(logic [7:0] ch);
    logic        digit;
    logic [3:0]  d;
    logic [11:0] sp;
    logic [34:0] tk;
    digit = (ch >= CH_ZERO && ch <= CH_NINE);
    d     = 4'(ch - CH_ZERO);
    if (ln_len >= LINE_LIMIT) begin
      return;
    end
    ln_len = ln_len + 8'd1;
    case (ln_phase)
      LN_DIR: begin
        if (ch == CH_NUL) begin
          ln_phase = LN_END_EMPTY;
        end else begin
          ln_dir   = ch;
          ln_phase = LN_AFTER_DIR;
        end
      end
      LN_AFTER_DIR, LN_SPEED: begin
        if (ch == CH_NUL && ln_phase == LN_AFTER_DIR) begin
          ln_phase = LN_END_DIR;
        end else if (digit) begin
          if (!ln_speed_bad) begin
            sp = {3'b0, ln_speed} * 12'd10 + {8'b0, d};
            if (sp > {3'b0, SPEED_MAX}) begin
              ln_speed_bad = 1'b1;
              ln_speed     = SPEED_SAT;
            end else begin
              ln_speed = sp[8:0];
            end
          end
          ln_phase = LN_SPEED;
        end else if (ch == CH_COMMA && ln_phase == LN_SPEED) begin
          ln_phase = LN_TICKS;
        end else begin
          ln_phase = LN_END_SPEED;
        end
      end
      LN_TICKS: begin
        if (digit) begin
          tk = {4'b0, ln_ticks} * 35'd10 + {31'b0, d};
          ln_ticks = (tk > {4'b0, TICKS_SAT}) ? TICKS_SAT : tk[30:0];
        end else begin
          ln_phase = LN_END_SPEED;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Count one encoder tick; return high when the target has been passed
  function automatic logic model_tick();
    logic [32:0] cnt;
    logic [9:0]  nv;
    nv = '0;
    if (m_ticks < TICK_MAX) begin
      m_ticks = m_ticks + 32'd1;
    end
    if (m_target == '0) begin
      return 1'b0;
    end
    if (m_ticks > m_target) begin
      motor_halt();
      return 1'b1;
    end
    if (cf_slow) begin
      cnt = {1'b0, m_ticks};
      if (cnt + {17'b0, cf_near} > {1'b0, m_target}) begin
        nv = {2'b0, m_power} >> 1;
      end else if (cnt + {17'b0, cf_far} > {1'b0, m_target}) begin
        nv = ({2'b0, m_power} << 2) / 10'd5;
      end
      if (nv != '0) begin
        m_duty = nv[7:0];
      end
    end
    return 1'b0;
  endfunction

  function automatic motor_status_t model_step(logic mode, logic [7:0] ch);
    motor_status_t s;
    line_result_t  res;
    s = '0;
    if (mode) begin
      s.target_reached = model_tick();
    end else if (ch == CH_CR) begin
      res = model_end_line();
      s.command_done    = (res == LINE_DONE);
      s.command_unknown = (res == LINE_UNKNOWN);
    end else if (ch != CH_LF) begin
      model_char(ch);
    end
    s.drive_a = m_pins[0];
    s.drive_b = m_pins[1];
    s.duty    = m_duty;
    s.moving  = m_moving;
    return s;
  endfunction

  function automatic motor_status_t status(logic a, logic b, logic [7:0] duty, logic mov,
                                           logic reached, logic done, logic unknown);
    motor_status_t s;
    s = '{a, b, duty, mov, reached, done, unknown};
    return s;
  endfunction

  function automatic stim_row_t row(logic mode, logic [7:0] ch, logic typed = 1'b0,
                                    motor_status_t st = '0);
    stim_row_t r;
    r = '{mode, ch, typed, st};
    return r;
  endfunction

  // Append the decimal digits of a value to the line under construction
  function automatic void push_decimal(longint unsigned v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) line_buf.push_back({1'b0, digits[i]});
  endfunction

  function automatic void push_digit_run(int unsigned count);
    repeat (count) line_buf.push_back({1'b0, CH_ZERO + 8'($urandom_range(0, 9))});
  endfunction

  // Offer one input beat, with an optional idle burst ahead of it
  task automatic push_item(logic mode, logic [7:0] ch, logic typed = 1'b0,
                           motor_status_t st = '0);
    motor_status_t predicted;
    int unsigned   gap;
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   = 1'b1;
    in_mode    = mode;
    in_rx_byte = ch;
    do @(posedge clk); while (!in_ready);
    predicted = model_step(mode, ch);
    status_q.push_back(typed ? st : predicted);
    items_sent++;
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SLOW_DOWN: cf_slow = val[0];
      REG_NEAR_WIN:  cf_near = val;
      REG_FAR_WIN:   cf_far  = val;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Build one line (mostly well formed), send it with CR, then a run of ticks
  task automatic send_random_line(logic force_long);
    int unsigned kind;
    int unsigned sel;
    int unsigned n_ticks;
    logic [7:0]  ch;
    line_buf.delete();
    kind = force_long ? 99 : $urandom_range(0, 99);
    if (kind == 99 && long_lines >= MAX_LONG) begin
      kind = 0;
    end
    if (kind < 72) begin
      sel = $urandom_range(0, 9);
      ch = (sel < 4) ? CH_F : (sel < 8) ? CH_B : (sel < 9) ? CH_S : 8'($urandom_range(1, 255));
      if (ch == CH_CR || ch == CH_LF) begin
        ch = CH_JUNK;
      end
      line_buf.push_back({1'b0, ch});
      sel = $urandom_range(0, 9);
      if (sel != 0) begin
        case (sel)
          1:       line_buf.push_back({1'b0, CH_ZERO});
          2:       push_decimal($urandom_range(256, 999));
          3:       push_digit_run($urandom_range(5, 12));
          default: push_decimal($urandom_range(1, 255));
        endcase
        if ($urandom_range(0, 3) != 0) begin
          line_buf.push_back({1'b0, CH_COMMA});
          sel = $urandom_range(0, 9);
          if (sel == 1) begin
            push_digit_run($urandom_range(10, 14));
          end else if (sel != 0) begin
            push_decimal($urandom_range(1, 200));
          end
        end
        if ($urandom_range(0, 7) == 0) begin
          ch = 8'($urandom_range(0, 255));
          line_buf.push_back({1'b0, (ch == CH_CR) ? CH_JUNK : ch});
        end
      end
    end else if (kind < 99) begin
      // Noise: stray bytes, terminators and ticks mixed into a line
      repeat ($urandom_range(0, 10)) begin
        sel = $urandom_range(0, 9);
        case (sel)
          0:       line_buf.push_back({1'b1, 8'($urandom_range(0, 255))});
          1:       line_buf.push_back({1'b0, CH_LF});
          2:       line_buf.push_back({1'b0, CH_NUL});
          3:       line_buf.push_back({1'b0, CH_COMMA});
          4:       line_buf.push_back({1'b0, CH_ZERO + 8'($urandom_range(0, 9))});
          5:       line_buf.push_back({1'b0, ($urandom_range(0, 1) != 0) ? CH_F : CH_B});
          default: line_buf.push_back({1'b0, 8'($urandom_range(0, 255))});
        endcase
      end
    end else begin
      // Overlong line: a valid command followed by filler past the limit
      long_lines++;
      line_buf.push_back({1'b0, ($urandom_range(0, 1) != 0) ? CH_F : CH_B});
      push_decimal($urandom_range(1, 255));
      repeat ($urandom_range(200, 215)) begin
        ch = 8'($urandom_range(0, 255));
        line_buf.push_back({1'b0, (ch == CH_CR) ? CH_JUNK : ch});
      end
    end
    foreach (line_buf[i]) push_item(line_buf[i][8], line_buf[i][7:0]);
    push_item(1'b0, CH_CR);
    // Tick up to and just past the target when it is close, else a few ticks
    if (m_target != '0 && m_target - m_ticks < 300) begin
      n_ticks = (m_target - m_ticks) + $urandom_range(0, 3);
      if ($urandom_range(0, 4) == 0) begin
        n_ticks = $urandom_range(0, n_ticks);
      end
    end else begin
      n_ticks = $urandom_range(0, 12);
    end
    repeat (n_ticks) push_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Result sink with random stall bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    motor_status_t got;
    motor_status_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_drive_a, out_drive_b, out_duty, out_moving,
              out_target_reached, out_command_done, out_command_unknown};
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected beat: a=%0b b=%0b duty=%0d mov=%0b reach=%0b done=%0b unk=%0b",
                   got.drive_a, got.drive_b, got.duty, got.moving,
                   got.target_reached, got.command_done, got.command_unknown);
        end
      end else begin
        want = status_q.pop_front();
        if (got.drive_a !== want.drive_a || got.drive_b !== want.drive_b ||
            got.duty !== want.duty || got.moving !== want.moving ||
            got.target_reached !== want.target_reached ||
            got.command_done !== want.command_done ||
            got.command_unknown !== want.command_unknown) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch at %0t", $time);
            $display("  exp a=%0b b=%0b duty=%0d mov=%0b reach=%0b done=%0b unk=%0b",
                     want.drive_a, want.drive_b, want.duty, want.moving,
                     want.target_reached, want.command_done, want.command_unknown);
            $display("  got a=%0b b=%0b duty=%0d mov=%0b reach=%0b done=%0b unk=%0b",
                     got.drive_a, got.drive_b, got.duty, got.moving,
                     got.target_reached, got.command_done, got.command_unknown);
          end
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] phase_slow[N_PHASES];
    logic [15:0] phase_near[N_PHASES];
    logic [15:0] phase_far[N_PHASES];
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = 1'b0;
    in_rx_byte      = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    mismatches      = 0;
    items_sent      = 0;
    idle_cycles     = 0;
    long_lines      = 0;
    sender_idle_pct = 20;
    sink_idle_pct   = 20;
    model_reset();

    // Slowdown setting, near window, far window for each phase
    phase_slow = '{16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0};
    phase_near = '{NEAR_WIN_RST, 16'd50, 16'd0, 16'hFFFF,
                   16'($urandom_range(0, 60)), 16'd0};
    phase_far  = '{FAR_WIN_RST, 16'd100, 16'hFFFF, 16'd0,
                   16'($urandom_range(0, 150)), 16'd0};

    // Directed beats: a tick, then lines empty, bare letter, full command, target, bad speed, junk
    directed_rows = '{
      row(1'b1, 8'hFF,     1'b1, status(1'b0, 1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0)),
      row(1'b0, CH_CR,     1'b1, status(1'b0, 1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 1'b1)),
      row(1'b0, CH_F),
      row(1'b0, CH_LF),
      row(1'b0, CH_CR,     1'b1, status(1'b1, 1'b0, 8'd255, 1'b1, 1'b0, 1'b1, 1'b0)),
      row(1'b0, CH_B),
      row(1'b0, CH_ZERO + 8'd2),
      row(1'b0, CH_ZERO + 8'd5),
      row(1'b0, CH_ZERO + 8'd5),
      row(1'b0, CH_COMMA),
      row(1'b0, CH_ZERO + 8'd3),
      row(1'b0, CH_CR,     1'b1, status(1'b0, 1'b1, 8'd255, 1'b1, 1'b0, 1'b1, 1'b0)),
      row(1'b1, 8'h00),
      row(1'b1, 8'h55),
      row(1'b1, 8'hAA),
      row(1'b1, 8'h0F,     1'b1, status(1'b0, 1'b0, 8'd255, 1'b0, 1'b1, 1'b0, 1'b0)),
      row(1'b0, CH_F),
      row(1'b0, CH_ZERO + 8'd2),
      row(1'b0, CH_ZERO + 8'd5),
      row(1'b0, CH_ZERO + 8'd6),
      row(1'b0, CH_CR,     1'b1, status(1'b0, 1'b0, 8'd255, 1'b0, 1'b0, 1'b1, 1'b0)),
      row(1'b0, CH_JUNK),
      row(1'b0, CH_CR,     1'b1, status(1'b0, 1'b0, 8'd255, 1'b0, 1'b0, 1'b0, 1'b1)),
      row(1'b0, CH_NUL),
      row(1'b0, CH_CR,     1'b1, status(1'b0, 1'b0, 8'd255, 1'b0, 1'b0, 1'b0, 1'b1))
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      push_item(directed_rows[i].mode, directed_rows[i].ch,
                directed_rows[i].typed, directed_rows[i].status);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      if (p != 0) begin
        drain_results();
        write_reg(REG_SLOW_DOWN, phase_slow[p]);
        write_reg(REG_NEAR_WIN,  phase_near[p]);
        write_reg(REG_FAR_WIN,   phase_far[p]);
      end
      // Final phase runs flat out on both sides
      if (p == N_PHASES - 1) begin
        sender_idle_pct = 0;
        sink_idle_pct   = 0;
      end else begin
        sender_idle_pct = $urandom_range(5, 40);
        sink_idle_pct   = $urandom_range(5, 40);
      end
      if (p == 1) begin
        send_random_line(1'b1);
      end
      while (items_sent < (p + 1) * PHASE_ITEMS) begin
        if (p != N_PHASES - 1 && $urandom_range(0, 49) == 0) begin
          drain_results();
        end
        send_random_line(1'b0);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/scmc_pkg.sv
rtl/scmc_parser.sv
rtl/scmc_queue.sv
rtl/scmc_motor.sv
rtl/serial_command_motor_controller.sv
test/tb_top.sv
